[design/log_record_deframer_unit_macros.svh]
// ----------------------------------------------------------------------------
// log record deframer assertion macros
// shared clocking and reset gating for concurrent checks
// ----------------------------------------------------------------------------
`ifndef LOG_RECORD_DEFRAMER_UNIT_MACROS_SVH
`define LOG_RECORD_DEFRAMER_UNIT_MACROS_SVH

// plain property, sampled on clk_i, off during reset
`define LDF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// same-cycle implication
`define LDF_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LDF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ldf_pkg.sv]
// ----------------------------------------------------------------------------
// ldf_pkg
// types and constants shared by the deframer modules, and the parser's crc byte step
// ----------------------------------------------------------------------------
package ldf_pkg;

  // fixed body after the crc field: offset, timestamp, key and value lengths
  localparam int unsigned FixedBody = 8 + 8 + 4 + 4;
  localparam logic [31:0] MinLength = 32'(4 + FixedBody);
  localparam logic [31:0] NullLen   = 32'hFFFF_FFFF;
  localparam logic [32:0] LenBytes  = 33'd4;
  localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
  localparam int unsigned QueueDepthDefault = 2;

  typedef enum logic [1:0] {
    KIND_KEY    = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_REPORT = 2'd2
  } ldf_kind_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_TORN          = 3'd1,
    ST_LEN_SHORT     = 3'd2,
    ST_BAD_KEY_LEN   = 3'd3,
    ST_KEY_OVERRUN   = 3'd4,
    ST_BAD_VALUE_LEN = 3'd5,
    ST_SIZE_MISMATCH = 3'd6
  } ldf_status_e;

  // everything one input byte causes: an optional stream byte, then an
  // optional report
  typedef struct packed {
    logic               has_byte;
    ldf_kind_e          byte_kind;
    logic [7:0]         byte_val;
    logic               has_report;
    ldf_status_e        status;
    logic               crc_ok;
    logic signed [63:0] record_offset;
    logic signed [63:0] timestamp_ms;
    logic               key_present;
    logic               value_present;
    logic [32:0]        total_bytes;
  } ldf_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ldf_qstat_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[design/ldf_in_if.sv]
// ----------------------------------------------------------------------------
// ldf_in_if
// byte stream channel into the deframer: data bytes and flush markers
// ----------------------------------------------------------------------------
interface ldf_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

[design/ldf_out_if.sv]
// ----------------------------------------------------------------------------
// ldf_out_if
// result channel out of the deframer: key and value bytes and record reports
// ----------------------------------------------------------------------------
interface ldf_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         payload_byte;
  logic               last;
  logic [2:0]         status;
  logic               crc_ok;
  logic signed [63:0] record_offset;
  logic signed [63:0] timestamp_ms;
  logic               key_present;
  logic               value_present;
  logic [32:0]        total_bytes;

  modport source (
    output valid, output kind, output payload_byte, output last, output status,
    output crc_ok, output record_offset, output timestamp_ms, output key_present,
    output value_present, output total_bytes, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input last, input status,
    input crc_ok, input record_offset, input timestamp_ms, input key_present,
    input value_present, input total_bytes, output ready
  );
endinterface

[design/log_record_deframer_unit.sv]
// ----------------------------------------------------------------------------
// log_record_deframer_unit
// parses length-prefixed log records from a byte stream and checks crc-32
// ----------------------------------------------------------------------------
// in_i carries one stream byte per transfer (mode low) or a flush marker
// (mode high). out_o carries key bytes, value bytes and one report per
// record, with last set on the final result of each input transfer.
// every result is registered in the fifo before it is offered; the report of
// a last value byte follows its byte as a second result of the same entry.
// throughput: one input byte per cycle while the fifo is not full; the parser
// assembles fields and advances crc-32 one byte a cycle. the output side drains
// one result per cycle while out_o is ready; only a last value byte gives two.
// a report with an error status puts the parser into skip until a flush; a
// flush inside a record gives a torn report.
// reset: the parser waits for a length field and the fifo is empty.
// stall: while out_o is stalled the fifo keeps taking entries; once it
// holds QueueDepth entries in_i.ready drops until the head entry has sent
// its last result.
// ----------------------------------------------------------------------------
module log_record_deframer_unit
  import ldf_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ldf_in_if.sink     in_i,
  ldf_out_if.source  out_o
);

  // parser to fifo
  logic       push;
  ldf_entry_t entry;
  // fifo to output sequencer
  ldf_entry_t head;
  ldf_qstat_t qstat;
  logic       pop;

  // front: field assembly, crc and checks, one byte per cycle while the fifo has room
  ldf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .qstat_i (qstat),
    .push_o  (push),
    .entry_o (entry)
  );

  // decoupling fifo, each entry holds all results of one input transfer
  ldf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  // back: one result transfer per cycle from the fifo head while out_o is ready
  ldf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .qstat_i (qstat),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

[design/ldf_front.sv]
// ----------------------------------------------------------------------------
// ldf_front
// record parser: field assembly, crc, length checks, result classification
// ----------------------------------------------------------------------------
`include "log_record_deframer_unit_macros.svh"

module ldf_front
  import ldf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ldf_in_if.sink      in_i,
  input  ldf_qstat_t  qstat_i,
  output logic        push_o,
  output ldf_entry_t  entry_o
);

  typedef enum logic [8:0] {
    PH_LEN  = 9'b0_0000_0001,
    PH_CRC  = 9'b0_0000_0010,
    PH_OFF  = 9'b0_0000_0100,
    PH_TS   = 9'b0_0000_1000,
    PH_KLEN = 9'b0_0001_0000,
    PH_KEY  = 9'b0_0010_0000,
    PH_VLEN = 9'b0_0100_0000,
    PH_VAL  = 9'b0_1000_0000,
    PH_ERR  = 9'b1_0000_0000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  field_count_q, field_count_d;
  logic [63:0] field_shift_q, field_shift_d;
  logic [31:0] record_length_q, record_length_d;
  logic [31:0] stored_crc_q, stored_crc_d;
  logic [31:0] running_crc_q, running_crc_d;
  logic [63:0] offset_q, offset_d;
  logic [63:0] timestamp_q, timestamp_d;
  logic        key_flag_q, key_flag_d;
  logic        value_flag_q, value_flag_d;
  logic [31:0] bytes_left_q, bytes_left_d;
  logic [31:0] body_left_q, body_left_d;

  logic        take;
  logic [63:0] v;
  logic [31:0] w;
  logic [31:0] crc_next;
  logic [31:0] body_dec;
  logic        crc_match;
  logic [32:0] rec_total;
  logic [2:0]  last_idx;
  logic [31:0] len;
  logic        in_body;
  ldf_entry_t  entry;

  assign in_i.ready = !qstat_i.full;
  assign take       = in_i.valid && in_i.ready;

  assign v         = {field_shift_q[55:0], in_i.data_byte};
  assign w         = v[31:0];
  assign crc_next  = crc32_byte(running_crc_q, in_i.data_byte);
  assign body_dec  = body_left_q - 32'd1;
  assign crc_match = (~crc_next == stored_crc_q);
  assign rec_total = {1'b0, record_length_q} + LenBytes;
  assign last_idx  = (phase_q == PH_OFF || phase_q == PH_TS) ? 3'd7 : 3'd3;
  assign in_body   = phase_q inside {PH_OFF, PH_TS, PH_KLEN, PH_KEY, PH_VLEN, PH_VAL};

  always_comb begin
    phase_d         = phase_q;
    field_count_d   = field_count_q;
    field_shift_d   = field_shift_q;
    record_length_d = record_length_q;
    stored_crc_d    = stored_crc_q;
    running_crc_d   = running_crc_q;
    offset_d        = offset_q;
    timestamp_d     = timestamp_q;
    key_flag_d      = key_flag_q;
    value_flag_d    = value_flag_q;
    bytes_left_d    = bytes_left_q;
    body_left_d     = body_left_q;
    len             = '0;
    entry           = '0;

    if (take) begin
      if (in_i.mode) begin
        // flush: torn report only when a record is partly in and not being skipped
        if (!(phase_q == PH_ERR || (phase_q == PH_LEN && field_count_q == 3'd0))) begin
          entry.has_report  = 1'b1;
          entry.status      = ST_TORN;
          entry.total_bytes = (phase_q != PH_LEN) ? rec_total : '0;
        end
        phase_d       = PH_LEN;
        field_count_d = '0;
        field_shift_d = '0;
      end else if (phase_q != PH_ERR) begin
        if (in_body) begin
          running_crc_d = crc_next;
          body_left_d   = body_dec;
        end
        case (phase_q)
          PH_KEY: begin
            entry.has_byte  = 1'b1;
            entry.byte_kind = KIND_KEY;
            entry.byte_val  = in_i.data_byte;
            bytes_left_d    = bytes_left_q - 32'd1;
            if (bytes_left_q == 32'd1) begin
              phase_d = PH_VLEN;
            end
          end
          PH_VAL: begin
            entry.has_byte  = 1'b1;
            entry.byte_kind = KIND_VALUE;
            entry.byte_val  = in_i.data_byte;
            bytes_left_d    = bytes_left_q - 32'd1;
            if (bytes_left_q == 32'd1) begin
              entry.has_report    = 1'b1;
              entry.status        = ST_OK;
              entry.crc_ok        = crc_match;
              entry.record_offset = offset_q;
              entry.timestamp_ms  = timestamp_q;
              entry.key_present   = key_flag_q;
              entry.value_present = value_flag_q;
              entry.total_bytes   = rec_total;
              phase_d             = PH_LEN;
            end
          end
          default: begin
            field_shift_d = v;
            field_count_d = field_count_q + 3'd1;
            if (field_count_q == last_idx) begin
              field_shift_d = '0;
              field_count_d = '0;
              case (phase_q)
                PH_LEN: begin
                  record_length_d = w;
                  if (w < MinLength) begin
                    entry.has_report  = 1'b1;
                    entry.status      = ST_LEN_SHORT;
                    entry.total_bytes = {1'b0, w} + LenBytes;
                    phase_d           = PH_ERR;
                  end else begin
                    body_left_d   = w - 32'd4;
                    running_crc_d = '1;
                    phase_d       = PH_CRC;
                  end
                end
                PH_CRC: begin
                  stored_crc_d = w;
                  phase_d      = PH_OFF;
                end
                PH_OFF: begin
                  offset_d = v;
                  phase_d  = PH_TS;
                end
                PH_TS: begin
                  timestamp_d = v;
                  phase_d     = PH_KLEN;
                end
                PH_KLEN: begin
                  key_flag_d = (w != NullLen);
                  len        = (w == NullLen) ? '0 : w;
                  if (w != NullLen && w[31]) begin
                    entry.has_report  = 1'b1;
                    entry.status      = ST_BAD_KEY_LEN;
                    entry.total_bytes = rec_total;
                    phase_d           = PH_ERR;
                  end else if (({1'b0, len} + LenBytes) > {1'b0, body_dec}) begin
                    entry.has_report  = 1'b1;
                    entry.status      = ST_KEY_OVERRUN;
                    entry.total_bytes = rec_total;
                    phase_d           = PH_ERR;
                  end else begin
                    bytes_left_d = len;
                    phase_d      = (len != '0) ? PH_KEY : PH_VLEN;
                  end
                end
                PH_VLEN: begin
                  value_flag_d = (w != NullLen);
                  len          = (w == NullLen) ? '0 : w;
                  if (w != NullLen && w[31]) begin
                    entry.has_report  = 1'b1;
                    entry.status      = ST_BAD_VALUE_LEN;
                    entry.total_bytes = rec_total;
                    phase_d           = PH_ERR;
                  end else if (len != body_dec) begin
                    entry.has_report  = 1'b1;
                    entry.status      = ST_SIZE_MISMATCH;
                    entry.total_bytes = rec_total;
                    phase_d           = PH_ERR;
                  end else if (len == '0) begin
                    // empty or null value ends the record here
                    entry.has_report    = 1'b1;
                    entry.status        = ST_OK;
                    entry.crc_ok        = crc_match;
                    entry.record_offset = offset_q;
                    entry.timestamp_ms  = timestamp_q;
                    entry.key_present   = key_flag_q;
                    entry.value_present = (w != NullLen);
                    entry.total_bytes   = rec_total;
                    phase_d             = PH_LEN;
                  end else begin
                    bytes_left_d = len;
                    phase_d      = PH_VAL;
                  end
                end
                default: begin
                  phase_d = phase_q;
                end
              endcase
            end
          end
        endcase
      end
    end
  end

  assign entry_o = entry;
  assign push_o  = take && (entry.has_byte || entry.has_report);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_LEN;
      field_count_q   <= '0;
      field_shift_q   <= '0;
      record_length_q <= '0;
      stored_crc_q    <= '0;
      running_crc_q   <= '1;
      offset_q        <= '0;
      timestamp_q     <= '0;
      key_flag_q      <= 1'b0;
      value_flag_q    <= 1'b0;
      bytes_left_q    <= '0;
      body_left_q     <= '0;
    end else begin
      phase_q         <= phase_d;
      field_count_q   <= field_count_d;
      field_shift_q   <= field_shift_d;
      record_length_q <= record_length_d;
      stored_crc_q    <= stored_crc_d;
      running_crc_q   <= running_crc_d;
      offset_q        <= offset_d;
      timestamp_q     <= timestamp_d;
      key_flag_q      <= key_flag_d;
      value_flag_q    <= value_flag_d;
      bytes_left_q    <= bytes_left_d;
      body_left_q     <= body_left_d;
    end
  end

  `LDF_ASSERT_IMPL(push_needs_transfer, push_o, in_i.valid && in_i.ready, "push without input transfer")
  `LDF_ASSERT_NEXT(error_enters_skip, push_o && entry_o.has_report && entry_o.status != ST_OK && entry_o.status != ST_TORN, phase_q == PH_ERR, "error report did not enter skip")

endmodule

[design/ldf_queue.sv]
// ----------------------------------------------------------------------------
// ldf_queue
// short fifo of classified entries between parser and output sequencer
// ----------------------------------------------------------------------------
`include "log_record_deframer_unit_macros.svh"

module ldf_queue
  import ldf_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  ldf_entry_t  entry_i,
  input  logic        pop_i,
  output ldf_entry_t  head_o,
  output ldf_qstat_t  qstat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ldf_entry_t        mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  assign qstat_o.full  = (cnt_q == CntW'(Depth));
  assign qstat_o.empty = (cnt_q == '0);
  assign head_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `LDF_ASSERT(count_in_range, cnt_q <= CntW'(Depth), "fifo count beyond depth")
  `LDF_ASSERT_IMPL(no_push_when_full, push_i, !qstat_o.full, "push into full fifo")

endmodule

[design/ldf_back.sv]
// ----------------------------------------------------------------------------
// ldf_back
// output sequencer: expands one entry into its byte and report transfers
// ----------------------------------------------------------------------------
`include "log_record_deframer_unit_macros.svh"

module ldf_back
  import ldf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ldf_entry_t  head_i,
  input  ldf_qstat_t  qstat_i,
  output logic        pop_o,
  ldf_out_if.source   out_o
);

  // set once the byte of a two-result entry has gone out
  logic sel_q, sel_d;
  logic byte_sel;
  logic last;
  logic xfer;

  assign byte_sel = head_i.has_byte && !sel_q;
  assign last     = !(byte_sel && head_i.has_report);
  assign xfer     = out_o.valid && out_o.ready;
  assign pop_o    = xfer && last;

  always_comb begin
    out_o.valid = !qstat_i.empty;
    out_o.last  = last;
    if (byte_sel) begin
      out_o.kind          = head_i.byte_kind;
      out_o.payload_byte  = head_i.byte_val;
      out_o.status        = ST_OK;
      out_o.crc_ok        = 1'b0;
      out_o.record_offset = '0;
      out_o.timestamp_ms  = '0;
      out_o.key_present   = 1'b0;
      out_o.value_present = 1'b0;
      out_o.total_bytes   = '0;
    end else begin
      out_o.kind          = KIND_REPORT;
      out_o.payload_byte  = '0;
      out_o.status        = head_i.status;
      out_o.crc_ok        = head_i.crc_ok;
      out_o.record_offset = head_i.record_offset;
      out_o.timestamp_ms  = head_i.timestamp_ms;
      out_o.key_present   = head_i.key_present;
      out_o.value_present = head_i.value_present;
      out_o.total_bytes   = head_i.total_bytes;
    end
  end

  always_comb begin
    sel_d = sel_q;
    if (xfer) begin
      sel_d = !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

  `LDF_ASSERT_IMPL(no_pop_when_empty, pop_o, !qstat_i.empty, "pop from empty fifo")

endmodule

[dv/log_record_deframer_checker.sv]
// ----------------------------------------------------------------------------
// log_record_deframer_checker
// watches both channels of the deframer, predicts every result of each input
// transfer and compares the output stream against those predictions in order
// ----------------------------------------------------------------------------
module log_record_deframer_checker
  import ldf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ldf_in_if           in_i,
  ldf_out_if          out_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxReports = 10;

  typedef enum logic [3:0] {
    PARSE_LEN,
    PARSE_CRC,
    PARSE_OFFSET,
    PARSE_TSTAMP,
    PARSE_KEY_LEN,
    PARSE_KEY,
    PARSE_VALUE_LEN,
    PARSE_VALUE,
    PARSE_SKIP
  } parse_e;

  typedef struct packed {
    ldf_kind_e   kind;
    logic [7:0]  payload;
    logic        last;
    ldf_status_e status;
    logic        crc_ok;
    logic [63:0] offset;
    logic [63:0] tstamp;
    logic        key_present;
    logic        value_present;
    logic [32:0] total;
  } result_t;

  parse_e      parse_q;
  logic [2:0]  field_idx;
  logic [63:0] field_acc;
  logic [31:0] rec_len;
  logic [31:0] crc_field;
  logic [31:0] crc_acc;
  logic [63:0] offset_acc;
  logic [63:0] tstamp_acc;
  logic        key_seen;
  logic        value_seen;
  logic [31:0] chunk_left;
  logic [31:0] body_left;

  result_t     expected_q[$];
  result_t     step_res[$];

  function automatic logic [31:0] crc_update(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    repeat (8) c = {1'b0, c[31:1]} ^ (c[0] ? CrcPoly : 32'd0);
    return c;
  endfunction

  function automatic int unsigned field_width(parse_e p);
    return (p == PARSE_OFFSET || p == PARSE_TSTAMP) ? 8 : 4;
  endfunction

  // error reports carry only the total, and that only once the length is known
  function automatic result_t record_report(ldf_status_e st);
    result_t r;
    r        = '0;
    r.kind   = KIND_REPORT;
    r.status = st;
    if (st == ST_OK) begin
      r.crc_ok        = (~crc_acc == crc_field);
      r.offset        = offset_acc;
      r.tstamp        = tstamp_acc;
      r.key_present   = key_seen;
      r.value_present = value_seen;
    end
    if (st == ST_OK || parse_q != PARSE_LEN) r.total = {1'b0, rec_len} + LenBytes;
    return r;
  endfunction

  function automatic result_t stream_byte(ldf_kind_e k, logic [7:0] b);
    result_t r;
    r         = '0;
    r.kind    = k;
    r.payload = b;
    return r;
  endfunction

  function automatic void abort_record(ldf_status_e st);
    step_res.push_back(record_report(st));
    parse_q = PARSE_SKIP;
  endfunction

  function automatic void close_field();
    logic [63:0] v;
    logic [31:0] w;
    logic [32:0] n;
    v         = field_acc;
    w         = v[31:0];
    field_acc = '0;
    field_idx = '0;
    case (parse_q)
      PARSE_LEN: begin
        rec_len = w;
        parse_q = PARSE_CRC;
        if (w < MinLength) begin
          abort_record(ST_LEN_SHORT);
        end else begin
          body_left = w - 32'd4;
          crc_acc   = '1;
        end
      end
      PARSE_CRC: begin
        crc_field = w;
        parse_q   = PARSE_OFFSET;
      end
      PARSE_OFFSET: begin
        offset_acc = v;
        parse_q    = PARSE_TSTAMP;
      end
      PARSE_TSTAMP: begin
        tstamp_acc = v;
        parse_q    = PARSE_KEY_LEN;
      end
      PARSE_KEY_LEN: begin
        if (w != NullLen && w[31]) begin
          abort_record(ST_BAD_KEY_LEN);
        end else begin
          key_seen = (w != NullLen);
          n        = key_seen ? {1'b0, w} : 33'd0;
          if (n + 33'd4 > {1'b0, body_left}) begin
            abort_record(ST_KEY_OVERRUN);
          end else begin
            chunk_left = n[31:0];
            parse_q    = (n == 0) ? PARSE_VALUE_LEN : PARSE_KEY;
          end
        end
      end
      PARSE_VALUE_LEN: begin
        if (w != NullLen && w[31]) begin
          abort_record(ST_BAD_VALUE_LEN);
        end else begin
          value_seen = (w != NullLen);
          n          = value_seen ? {1'b0, w} : 33'd0;
          if (n != {1'b0, body_left}) begin
            abort_record(ST_SIZE_MISMATCH);
          end else if (n == 0) begin
            step_res.push_back(record_report(ST_OK));
            parse_q = PARSE_LEN;
          end else begin
            chunk_left = n[31:0];
            parse_q    = PARSE_VALUE;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_transfer(logic mode, logic [7:0] b);
    step_res.delete();
    if (mode) begin
      // flush: torn report unless nothing of a record is pending
      if (!(parse_q == PARSE_SKIP || (parse_q == PARSE_LEN && field_idx == 0)))
        step_res.push_back(record_report(ST_TORN));
      parse_q   = PARSE_LEN;
      field_idx = '0;
      field_acc = '0;
    end else if (parse_q != PARSE_SKIP) begin
      if (parse_q >= PARSE_OFFSET && parse_q <= PARSE_VALUE) begin
        crc_acc   = crc_update(crc_acc, b);
        body_left = body_left - 32'd1;
      end
      case (parse_q)
        PARSE_KEY: begin
          step_res.push_back(stream_byte(KIND_KEY, b));
          chunk_left = chunk_left - 32'd1;
          if (chunk_left == 0) parse_q = PARSE_VALUE_LEN;
        end
        PARSE_VALUE: begin
          step_res.push_back(stream_byte(KIND_VALUE, b));
          chunk_left = chunk_left - 32'd1;
          if (chunk_left == 0) begin
            step_res.push_back(record_report(ST_OK));
            parse_q = PARSE_LEN;
          end
        end
        default: begin
          field_acc = {field_acc[55:0], b};
          if (32'(field_idx) + 1 >= field_width(parse_q)) close_field();
          else field_idx = field_idx + 3'd1;
        end
      endcase
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) expected_q.push_back(step_res[i]);
  endfunction

  function automatic string describe(result_t r);
    return $sformatf({"kind %0d byte %h last %b status %0d crc_ok %b offset %h ts %h",
                      " key %b value %b total %h"}, r.kind, r.payload, r.last, r.status,
                     r.crc_ok, r.offset, r.tstamp, r.key_present, r.value_present, r.total);
  endfunction

  function automatic void log_failure(string what, result_t want, result_t got);
    mismatch_count_o++;
    if (mismatch_count_o <= MaxReports) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected %s", describe(want));
      $display("  actual   %s", describe(got));
    end
  endfunction

  function automatic void check_result();
    result_t got;
    result_t want;
    got.kind          = ldf_kind_e'(out_i.kind);
    got.payload       = out_i.payload_byte;
    got.last          = out_i.last;
    got.status        = ldf_status_e'(out_i.status);
    got.crc_ok        = out_i.crc_ok;
    got.offset        = out_i.record_offset;
    got.tstamp        = out_i.timestamp_ms;
    got.key_present   = out_i.key_present;
    got.value_present = out_i.value_present;
    got.total         = out_i.total_bytes;
    if (expected_q.size() == 0) begin
      log_failure("result transfer with nothing expected", '0, got);
    end else begin
      want = expected_q.pop_front();
      if (got !== want) log_failure("result mismatch", want, got);
    end
  endfunction

  // results are compared before the same edge's input is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q          = PARSE_LEN;
      field_idx        = '0;
      field_acc        = '0;
      rec_len          = '0;
      crc_field        = '0;
      crc_acc          = '1;
      offset_acc       = '0;
      tstamp_acc       = '0;
      key_seen         = 1'b0;
      value_seen       = 1'b0;
      chunk_left       = '0;
      body_left        = '0;
      mismatch_count_o = 0;
      expected_q.delete();
    end else begin
      if (out_i.valid && out_i.ready) check_result();
      if (in_i.valid && in_i.ready) predict_transfer(in_i.mode, in_i.data_byte);
    end
    pending_o = expected_q.size();
  end

endmodule

[dv/log_record_deframer_unit_test.sv]
// ----------------------------------------------------------------------------
// log_record_deframer_unit_test
// drives record streams into the deframer and gives the verdict
// ----------------------------------------------------------------------------
// a short directed pass walks every status, null and empty keys and values,
// field extremes and flushes in and between records; then random records,
// mostly well formed with random content, some broken, run through phases of
// sender gaps and receiver stalls. the checker beside the block predicts and
// compares every result transfer.
// ----------------------------------------------------------------------------
module log_record_deframer_unit_test;
  import ldf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkHalf     = 6;
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned PhaseItems  = 370;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
  } stream_item_t;

  logic         clk_i;
  logic         rst_ni;
  int unsigned  gap_pct;
  int unsigned  stall_pct;
  int unsigned  mismatches;
  int unsigned  pending;
  int unsigned  quiet_cycles;
  stream_item_t stream_q[$];

  ldf_in_if  in_bus ();
  ldf_out_if out_bus ();

  log_record_deframer_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  log_record_deframer_checker chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (in_bus),
    .out_i            (out_bus),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // receiver side: ready changes at the falling edge only
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog: too many cycles with no transfer on either channel
  initial begin
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("** log_record_deframer_unit: FAILED **");
    $finish;
  end

  // reflected crc-32 over the record body, for building correct records
  function automatic logic [31:0] crc_fold(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) c = (c >> 1) ^ CrcPoly;
      else c = c >> 1;
    end
    return c;
  endfunction

  // mostly random, sometimes a signed extreme
  function automatic logic [63:0] wide_value();
    case ($urandom_range(9))
      0: return 64'd0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_word(ref logic [7:0] q[$], input logic [63:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) q.push_back(v[8*i +: 8]);
  endtask

  task automatic push_flush();
    stream_q.push_back({1'b1, 8'($urandom)});
  endtask

  // builds one record with the given header fields; keep < 0 sends it whole,
  // otherwise only its first keep bytes go out
  task automatic queue_record(logic [31:0] len_f, logic [31:0] klen_f, logic [31:0] vlen_f,
                              int key_n, int val_n, logic [63:0] offset,
                              logic [63:0] tstamp, bit bad_crc, int keep);
    logic [7:0]  body[$];
    logic [7:0]  rec[$];
    logic [31:0] crc;
    push_word(body, offset, 8);
    push_word(body, tstamp, 8);
    push_word(body, klen_f, 4);
    repeat (key_n) body.push_back(8'($urandom));
    push_word(body, vlen_f, 4);
    repeat (val_n) body.push_back(8'($urandom));
    crc = '1;
    foreach (body[i]) crc = crc_fold(crc, body[i]);
    crc = ~crc;
    if (bad_crc) crc = crc ^ (32'd1 << $urandom_range(31));
    push_word(rec, len_f, 4);
    push_word(rec, crc, 4);
    foreach (body[i]) rec.push_back(body[i]);
    foreach (rec[i]) if (keep < 0 || i < keep) stream_q.push_back({1'b0, rec[i]});
  endtask

  task automatic queue_directed();
    // minimum length, null key and value, signed extremes
    queue_record(MinLength, NullLen, NullLen, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF,
                 64'h8000_0000_0000_0000, 1'b0, -1);
    // empty key and empty value, then a flush with nothing pending
    queue_record(MinLength, 32'd0, 32'd0, 0, 0, 64'd0, '1, 1'b0, -1);
    push_flush();
    // one key byte, one value byte
    queue_record(MinLength + 2, 32'd1, 32'd1, 1, 1, '1, 64'd0, 1'b0, -1);
    // corrupted crc
    queue_record(MinLength + 5, 32'd3, 32'd2, 3, 2, wide_value(), wide_value(), 1'b1, -1);
    // length one short of the minimum, skipped tail, and a second flush
    queue_record(MinLength - 1, 32'd0, 32'd0, 0, 0, 64'd0, 64'd0, 1'b0, 8);
    push_flush();
    push_flush();
    // zero length
    queue_record(32'd0, 32'd0, 32'd0, 0, 0, 64'd0, 64'd0, 1'b0, 4);
    push_flush();
    // key length below null
    queue_record(MinLength, 32'h8000_0000, 32'd0, 0, 0, 64'd1, 64'd1, 1'b0, -1);
    push_flush();
    // key runs past the record
    queue_record(MinLength, 32'd1, 32'd0, 1, 0, 64'd2, 64'd2, 1'b0, -1);
    push_flush();
    // value length below null
    queue_record(MinLength, 32'd0, 32'hFFFF_FFFE, 0, 0, 64'd3, 64'd3, 1'b0, -1);
    push_flush();
    // largest length, so the value length cannot match
    queue_record('1, 32'd0, 32'd0, 0, 0, 64'd4, 64'd4, 1'b0, -1);
    push_flush();
    // torn after the length field, then torn inside it
    queue_record(MinLength + 4, 32'd2, 32'd2, 2, 2, 64'd5, 64'd5, 1'b0, 10);
    push_flush();
    queue_record(MinLength, 32'd0, 32'd0, 0, 0, 64'd6, 64'd6, 1'b0, 2);
    push_flush();
  endtask

  task automatic queue_random_record();
    int unsigned pick;
    int          key_n;
    int          val_n;
    logic [31:0] len_f;
    logic [31:0] klen_f;
    logic [31:0] vlen_f;
    int          keep;
    bit          bad_crc;
    pick    = $urandom_range(99);
    key_n   = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
    val_n   = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
    klen_f  = key_n;
    vlen_f  = val_n;
    if ($urandom_range(7) == 0) begin
      klen_f = NullLen;
      key_n  = 0;
    end
    if ($urandom_range(7) == 0) begin
      vlen_f = NullLen;
      val_n  = 0;
    end
    len_f   = MinLength + key_n + val_n;
    bad_crc = ($urandom_range(9) == 0);
    keep    = -1;
    if (pick < 70) begin
      queue_record(len_f, klen_f, vlen_f, key_n, val_n, wide_value(), wide_value(),
                   bad_crc, keep);
      // now and then a flush between records
      if ($urandom_range(9) == 0) push_flush();
    end else begin
      case ($urandom_range(6))
        0: begin
          len_f = $urandom_range(MinLength - 1);
          keep  = 4 + $urandom_range(20);
        end
        1: begin
          klen_f = {1'b1, 31'($urandom)};
          if (klen_f == NullLen) klen_f = 32'h8000_0000;
        end
        2: begin
          key_n  = 1 + $urandom_range(8);
          klen_f = key_n;
          len_f  = MinLength + $urandom_range(key_n - 1);
        end
        3: begin
          vlen_f = {1'b1, 31'($urandom)};
          if (vlen_f == NullLen) vlen_f = 32'hFFFF_FFFE;
        end
        4: len_f = len_f + 1 + $urandom_range(5);
        5: keep = 1 + $urandom_range(26 + key_n + val_n);
        default: begin
          // raw noise, whatever the parser makes of it
          repeat (1 + $urandom_range(30)) stream_q.push_back({1'b0, 8'($urandom)});
        end
      endcase
      queue_record(len_f, klen_f, vlen_f, key_n, val_n, wide_value(), wide_value(),
                   bad_crc, keep);
      push_flush();
    end
  endtask

  // one input transfer; valid stays up across back-to-back items
  task automatic send_item(stream_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.mode      <= it.mode;
    in_bus.data_byte <= it.data;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drive_stream();
    while (stream_q.size() > 0) send_item(stream_q.pop_front());
  endtask

  initial begin
    in_bus.valid     = 1'b0;
    in_bus.mode      = 1'b0;
    in_bus.data_byte = 8'd0;
    gap_pct          = 0;
    stall_pct        = 0;
    rst_ni           = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    queue_directed();
    drive_stream();

    // idling phases: none, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 55;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 55;
        end
        default: begin
          gap_pct   = 26;
          stall_pct = 26;
        end
      endcase
      while (stream_q.size() < PhaseItems) queue_random_record();
      drive_stream();
    end
    in_bus.valid <= 1'b0;

    // drain, then let any late stray result show up
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("** log_record_deframer_unit: PASSED **");
    end else begin
      $display("** log_record_deframer_unit: FAILED **");
    end
    $finish;
  end

endmodule
